@@ hw/rtl/fdnr_pkg.sv @@
// ----------------------------------------------------------------------------
// fdnr_pkg: shared types and constants of the feedback delay network reverb
// Holds the controller-to-datapath command set, the status and configuration
// structures, and the saturation helper.
// ----------------------------------------------------------------------------
package fdnr_pkg;

    localparam int SW      = 24;          // sample width, Q1.23
    localparam int COEF_W  = 16;          // Q0.16 coefficient field
    localparam int CFG_W   = 64;          // one packed register
    localparam int LINE_W  = 2;           // line number, up to four lines
    localparam int STG_W   = 1;           // butterfly stage number
    localparam int PROD_W  = 42;          // 18-bit signed coefficient x sample
    localparam int WIDE_W  = 44;          // common width for saturation
    localparam int CNT_W   = 32;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_START,
        OP_ADDR,
        OP_LOAD,
        OP_TAP,
        OP_MUL_A,
        OP_MUL_B,
        OP_DAMP,
        OP_MUL_G,
        OP_GAIN,
        OP_BFLY,
        OP_PUSH,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic [LINE_W-1:0]   line;
        logic [STG_W-1:0]    stage;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
    } dp_status_t;

    typedef struct packed {
        logic [CFG_W-1:0] damping_coefs;
        logic [CFG_W-1:0] line_gains;
        logic [CFG_W-1:0] delay_lengths;
    } cfg_t;

    typedef struct packed {
        logic                 hit;
        logic signed [SW-1:0] val;
    } sat_t;

    // Clip a wide signed value to the sample range and flag the clip.
    function automatic sat_t sat_sample(input logic signed [WIDE_W-1:0] v);
        sat_t r;
        logic signed [WIDE_W-1:0] smax;
        logic signed [WIDE_W-1:0] smin;
        smax = WIDE_W'((64'sd1 <<< (SW - 1)) - 64'sd1);
        smin = -smax - WIDE_W'(1);
        if (v > smax) begin
            r.hit = 1'b1;
            r.val = smax[SW-1:0];
        end else if (v < smin) begin
            r.hit = 1'b1;
            r.val = smin[SW-1:0];
        end else begin
            r.hit = 1'b0;
            r.val = v[SW-1:0];
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/fdnr_datapath.sv @@
// ----------------------------------------------------------------------------
// fdnr_datapath: delay store, line state and shared multiplier
// Executes one command per cycle from the controller.
// ----------------------------------------------------------------------------
module fdnr_datapath #(
    parameter int LINES     = 4,
    parameter int MAX_DELAY = 4096
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  fdnr_pkg::dp_cmd_t              cmd,
    output fdnr_pkg::dp_status_t           status,
    input  fdnr_pkg::cfg_t                 cfg,
    input  logic signed [fdnr_pkg::SW-1:0] sample_in,
    output logic signed [fdnr_pkg::SW-1:0] sample_out,
    output logic                           overflow_now,
    output logic                           overflow_latched,
    output logic [fdnr_pkg::CNT_W-1:0]     overflow_count
);
    import fdnr_pkg::*;

    localparam int PTR_W  = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int LEN_W  = $clog2(MAX_DELAY + 1);
    localparam int LIDX_W = (LINES > 2) ? 2 : 1;
    localparam int AW     = LIDX_W + PTR_W;
    localparam int DEPTH  = LINES << PTR_W;
    localparam int XW     = SW + 2;

    logic signed [SW-1:0]     mem [DEPTH];
    logic signed [SW-1:0]     rdata_reg;
    logic [PTR_W-1:0]         ptr_reg [LINES];
    logic signed [SW-1:0]     s_reg [LINES];
    logic signed [XW-1:0]     x_reg [LINES];
    logic signed [XW-1:0]     x_bf [LINES];
    logic signed [SW-1:0]     in_reg;
    logic signed [XW-1:0]     tap_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic                     hit_reg;
    logic                     sticky_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [AW-1:0]            clr_reg;
    logic signed [SW-1:0]     out_sample_reg;
    logic                     out_now_reg;
    logic                     out_latched_reg;
    logic [CNT_W-1:0]         out_cnt_reg;

    logic [LIDX_W-1:0]        li;
    logic [COEF_W-1:0]        coef_a;
    logic [COEF_W-1:0]        coef_g;
    logic [COEF_W-1:0]        len16;
    logic [LEN_W-1:0]         len;
    logic [PTR_W-1:0]         ptr_fix;
    logic [PTR_W-1:0]         ptr_inc;
    logic [LEN_W-1:0]         ptr_plus;
    logic [COEF_W:0]          mul_coef;
    logic signed [SW-1:0]     mul_opd;
    logic signed [PROD_W-1:0] mul_out;
    logic signed [WIDE_W-1:0] damp_wide;
    logic signed [WIDE_W-1:0] gain_wide;
    sat_t                     sat_tap;
    sat_t                     sat_damp;
    sat_t                     sat_gain;
    sat_t                     sat_push;
    logic                     event_hit;

    assign li     = cmd.line[LIDX_W-1:0];
    assign coef_a = cfg.damping_coefs[COEF_W*li +: COEF_W];
    assign coef_g = cfg.line_gains[COEF_W*li +: COEF_W];
    assign len16  = cfg.delay_lengths[COEF_W*li +: COEF_W];

    // Delay length clamped to 2..MAX_DELAY.
    always_comb begin
        if (len16 < 16'd2) begin
            len = LEN_W'(2);
        end else if (32'(len16) > MAX_DELAY) begin
            len = LEN_W'(MAX_DELAY);
        end else begin
            len = LEN_W'(len16);
        end
    end

    assign ptr_fix  = (LEN_W'(ptr_reg[li]) >= len) ? '0 : ptr_reg[li];
    assign ptr_plus = LEN_W'(ptr_reg[li]) + LEN_W'(1);
    assign ptr_inc  = (ptr_plus >= len) ? '0 : ptr_plus[PTR_W-1:0];

    // Shared multiplier: 17-bit unsigned coefficient times a sample.
    always_comb begin
        case (cmd.op)
            OP_MUL_A: begin
                mul_coef = 17'h10000 - {1'b0, coef_a};
                mul_opd  = x_reg[li][SW-1:0];
            end
            OP_MUL_B: begin
                mul_coef = {1'b0, coef_a};
                mul_opd  = s_reg[li];
            end
            default: begin
                mul_coef = {1'b0, coef_g};
                mul_opd  = s_reg[li];
            end
        endcase
    end
    assign mul_out = $signed({1'b0, mul_coef}) * mul_opd;

    // Round half up at the 16-bit shift, then clip.
    assign damp_wide = (WIDE_W'(acc_reg) + WIDE_W'(prod_reg) + WIDE_W'(32768)) >>> 16;
    assign gain_wide = (WIDE_W'(prod_reg) + WIDE_W'(32768)) >>> 16;
    assign sat_tap   = sat_sample(WIDE_W'(tap_reg));
    assign sat_damp  = sat_sample(damp_wide);
    assign sat_gain  = sat_sample(gain_wide);
    assign sat_push  = sat_sample(WIDE_W'(x_reg[li]) + WIDE_W'(in_reg));

    always_comb begin
        case (cmd.op)
            OP_TAP:  event_hit = sat_tap.hit;
            OP_DAMP: event_hit = sat_damp.hit;
            OP_GAIN: event_hit = sat_gain.hit;
            OP_PUSH: event_hit = sat_push.hit;
            default: event_hit = 1'b0;
        endcase
    end

    // One butterfly stage over all lanes; unpaired lanes pass unchanged.
    always_comb begin
        for (int j = 0; j < LINES; j++) begin
            x_bf[j] = x_reg[j];
        end
        for (int j = 0; j < LINES; j++) begin
            if ((((j >> cmd.stage) & 1) == 0) && (j + (1 << cmd.stage) < LINES)) begin
                x_bf[j] = x_reg[j] + x_reg[j + (1 << cmd.stage)];
                x_bf[j + (1 << cmd.stage)] = x_reg[j] - x_reg[j + (1 << cmd.stage)];
            end
        end
    end

    // Delay store: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[{li, ptr_fix}];
        if (cmd.op == OP_CLEAR) begin
            mem[clr_reg] <= '0;
        end else if (cmd.op == OP_PUSH) begin
            mem[{li, ptr_reg[li]}] <= sat_push.val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < LINES; j++) begin
                ptr_reg[j] <= '0;
                s_reg[j]   <= '0;
            end
            hit_reg    <= 1'b0;
            sticky_reg <= 1'b0;
            cnt_reg    <= '0;
            clr_reg    <= '0;
        end else begin
            if (event_hit) begin
                hit_reg    <= 1'b1;
                sticky_reg <= 1'b1;
                if (cnt_reg != '1) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            case (cmd.op)
                OP_CLEAR: clr_reg <= clr_reg + 1'b1;
                OP_START: hit_reg <= 1'b0;
                OP_ADDR:  ptr_reg[li] <= ptr_fix;
                OP_DAMP:  s_reg[li] <= sat_damp.val;
                OP_PUSH:  ptr_reg[li] <= ptr_inc;
                default: begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_START: begin
                in_reg  <= sample_in;
                tap_reg <= '0;
            end
            OP_LOAD: begin
                x_reg[li] <= XW'(rdata_reg);
                tap_reg   <= tap_reg + XW'(rdata_reg);
            end
            OP_TAP:   tap_reg <= XW'(sat_tap.val);
            OP_MUL_A: prod_reg <= mul_out;
            OP_MUL_B: begin
                acc_reg  <= prod_reg;
                prod_reg <= mul_out;
            end
            OP_MUL_G: prod_reg <= mul_out;
            OP_GAIN:  x_reg[li] <= XW'(sat_gain.val);
            OP_BFLY: begin
                for (int j = 0; j < LINES; j++) begin
                    x_reg[j] <= x_bf[j];
                end
            end
            OP_OUT: begin
                out_sample_reg  <= tap_reg[SW-1:0];
                out_now_reg     <= hit_reg;
                out_latched_reg <= sticky_reg;
                out_cnt_reg     <= cnt_reg;
            end
            default: begin
            end
        endcase
    end

    assign status.clear_last = (clr_reg == AW'(DEPTH - 1));
    assign sample_out        = out_sample_reg;
    assign overflow_now      = out_now_reg;
    assign overflow_latched  = out_latched_reg;
    assign overflow_count    = out_cnt_reg;

endmodule

@@ hw/rtl/fdnr_controller.sv @@
// ----------------------------------------------------------------------------
// fdnr_controller: sequencer of the reverb datapath
// Clears the delay store after reset, then steps each item through its phases.
// ----------------------------------------------------------------------------
module fdnr_controller #(
    parameter int LINES = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output fdnr_pkg::dp_cmd_t     cmd,
    input  fdnr_pkg::dp_status_t  status
);
    import fdnr_pkg::*;

    localparam int NSTAGE = $clog2(LINES);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_ADDR, ST_LOAD, ST_TAP, ST_MA, ST_MB,
        ST_DAMP, ST_MG, ST_GAIN, ST_BFLY, ST_PUSH, ST_FIN
    } state_t;

    state_t              state_reg;
    logic [LINE_W-1:0]   line_reg;
    logic [STG_W-1:0]    stage_reg;
    logic                out_valid_reg;
    logic                line_last;
    logic                stage_last;
    logic                out_free;

    assign line_last  = (line_reg == LINE_W'(LINES - 1));
    assign stage_last = (stage_reg == STG_W'(NSTAGE - 1));
    assign out_free   = !out_valid_reg || m_tready;

    always_comb begin
        cmd.line  = line_reg;
        cmd.stage = stage_reg;
        case (state_reg)
            ST_CLEAR: cmd.op = OP_CLEAR;
            ST_IDLE:  cmd.op = s_tvalid ? OP_START : OP_NONE;
            ST_ADDR:  cmd.op = OP_ADDR;
            ST_LOAD:  cmd.op = OP_LOAD;
            ST_TAP:   cmd.op = OP_TAP;
            ST_MA:    cmd.op = OP_MUL_A;
            ST_MB:    cmd.op = OP_MUL_B;
            ST_DAMP:  cmd.op = OP_DAMP;
            ST_MG:    cmd.op = OP_MUL_G;
            ST_GAIN:  cmd.op = OP_GAIN;
            ST_BFLY:  cmd.op = OP_BFLY;
            ST_PUSH:  cmd.op = OP_PUSH;
            ST_FIN:   cmd.op = out_free ? OP_OUT : OP_NONE;
            default:  cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            line_reg      <= '0;
            stage_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_FIN && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    if (status.clear_last) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    line_reg <= '0;
                    if (s_tvalid) begin
                        state_reg <= ST_ADDR;
                    end
                end
                ST_ADDR: state_reg <= ST_LOAD;
                ST_LOAD: begin
                    if (line_last) begin
                        line_reg  <= '0;
                        state_reg <= ST_TAP;
                    end else begin
                        line_reg  <= line_reg + 1'b1;
                        state_reg <= ST_ADDR;
                    end
                end
                ST_TAP:  state_reg <= ST_MA;
                ST_MA:   state_reg <= ST_MB;
                ST_MB:   state_reg <= ST_DAMP;
                ST_DAMP: state_reg <= ST_MG;
                ST_MG:   state_reg <= ST_GAIN;
                ST_GAIN: begin
                    if (line_last) begin
                        line_reg  <= '0;
                        stage_reg <= '0;
                        state_reg <= ST_BFLY;
                    end else begin
                        line_reg  <= line_reg + 1'b1;
                        state_reg <= ST_MA;
                    end
                end
                ST_BFLY: begin
                    if (stage_last) begin
                        state_reg <= ST_PUSH;
                    end else begin
                        stage_reg <= stage_reg + 1'b1;
                    end
                end
                ST_PUSH: begin
                    if (line_last) begin
                        state_reg <= ST_FIN;
                    end else begin
                        line_reg <= line_reg + 1'b1;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

@@ hw/rtl/feedback_delay_network_reverb.sv @@
// ----------------------------------------------------------------------------
// feedback_delay_network_reverb: four-line fixed-point FDN reverb
// Each item loads every line, runs damping and gain per line through the
// shared multiplier, applies the butterfly stages and pushes every line back;
// a new item is taken only once the last result is registered, and a result
// still held in the output register stalls the final step. Reset clears the
// control state and counters; the delay store is then swept to zero, all
// LINES << log2(MAX_DELAY) entries (16384 by default), before s_tready rises.
// ----------------------------------------------------------------------------
module feedback_delay_network_reverb #(
    parameter int LINES     = 4,
    parameter int MAX_DELAY = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] sample_in
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [23:0] sample_out, [24] overflow_now,
                                   // [25] overflow_latched, [57:26] overflow_count
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import fdnr_pkg::*;

    localparam logic [4:0] ADDR_DAMP = 5'd0;
    localparam logic [4:0] ADDR_GAIN = 5'd8;
    localparam logic [4:0] ADDR_LEN  = 5'd16;

    cfg_t                 cfg_reg;
    dp_cmd_t              cmd;
    dp_status_t           status;
    logic signed [SW-1:0] sample_out;
    logic                 overflow_now;
    logic                 overflow_latched;
    logic [CNT_W-1:0]     overflow_count;
    logic                 cfg_write;

    // Registers are written at the access phase; unknown addresses are ignored.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_write) begin
            case (paddr)
                ADDR_DAMP: cfg_reg.damping_coefs <= pwdata;
                ADDR_GAIN: cfg_reg.line_gains    <= pwdata;
                ADDR_LEN:  cfg_reg.delay_lengths <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr)
            ADDR_DAMP: prdata = cfg_reg.damping_coefs;
            ADDR_GAIN: prdata = cfg_reg.line_gains;
            ADDR_LEN:  prdata = cfg_reg.delay_lengths;
            default:   prdata = '0;
        endcase
    end

    // The controller sequences the phases of each item; the datapath owns
    // the delay store, the per-line state and the shared multiplier.
    fdnr_controller #(
        .LINES (LINES)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    fdnr_datapath #(
        .LINES     (LINES),
        .MAX_DELAY (MAX_DELAY)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .cfg              (cfg_reg),
        .sample_in        ($signed(s_tdata)),
        .sample_out       (sample_out),
        .overflow_now     (overflow_now),
        .overflow_latched (overflow_latched),
        .overflow_count   (overflow_count)
    );

    assign m_tdata = {6'd0, overflow_count, overflow_latched, overflow_now, sample_out};

endmodule
